// ===== rtl/ieqc_pkg.sv =====
package ieqc_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int KEY_COUNT   = 128;

   localparam int ADDR_W = $clog2(QUEUE_DEPTH);
   localparam int IDX_W  = ADDR_W + 1;
   localparam int KEY_W  = $clog2(KEY_COUNT);

   localparam logic [2:0] OP_KEY     = 3'd0;
   localparam logic [2:0] OP_BUTTON  = 3'd1;
   localparam logic [2:0] OP_DELTA   = 3'd2;
   localparam logic [2:0] OP_POS     = 3'd3;
   localparam logic [2:0] OP_POP     = 3'd4;
   localparam logic [2:0] OP_RECOVER = 3'd5;

   localparam logic [1:0] KIND_KEY    = 2'd0;
   localparam logic [1:0] KIND_BUTTON = 2'd1;
   localparam logic [1:0] KIND_DELTA  = 2'd2;
   localparam logic [1:0] KIND_POS    = 2'd3;

   typedef struct packed {
      logic [1:0]       kind;
      logic [KEY_W-1:0] key;
      logic             down;
      logic [15:0]      h;
      logic [15:0]      v;
   } entry_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic walk;
   } cmd_type;

   typedef struct packed {
      logic op_recover;
      logic walk_last;
   } status_type;

endpackage

// ===== rtl/ieqc_ctrl.sv =====
module ieqc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  ieqc_pkg::status_type status,
   output ieqc_pkg::cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_WALK = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.op_recover) begin
               state_in = ST_WALK;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (status.walk_last) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/ieqc_datapath.sv =====
module ieqc_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  ieqc_pkg::cmd_type                 cmd,
   output ieqc_pkg::status_type              status,
   input  logic [2:0]                        in_op,
   input  logic [ieqc_pkg::KEY_W-1:0]        in_key,
   input  logic                              in_pressed,
   input  logic [15:0]                       in_h,
   input  logic [15:0]                       in_v,
   output logic                              ev_valid,
   output logic [1:0]                        ev_kind,
   output logic [ieqc_pkg::KEY_W-1:0]        ev_key,
   output logic                              ev_down,
   output logic [15:0]                       ev_h,
   output logic [15:0]                       ev_v,
   output logic                              lost_flag,
   output logic [5:0]                        fill_level
);

   // latched transaction
   logic [2:0]                 op_ff;
   logic [ieqc_pkg::KEY_W-1:0] key_ff;
   logic                       down_ff;
   logic [15:0]                h_ff;
   logic [15:0]                v_ff;

   ieqc_pkg::entry_type mem [ieqc_pkg::QUEUE_DEPTH];
   ieqc_pkg::entry_type rdata_ff;

   logic [ieqc_pkg::IDX_W-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [ieqc_pkg::KEY_COUNT-1:0] map_ff, map_in;
   logic                           button_ff, button_in;
   logic [15:0]                    pos_h_ff, pos_h_in, pos_v_ff, pos_v_in;
   logic                           lost_ff, lost_in;
   logic                           ev_valid_ff, ev_valid_in;
   logic [ieqc_pkg::KEY_W-1:0]     walk_ff, walk_in;
   logic [1:0]                     newest_kind_ff, newest_kind_in;
   logic [15:0]                    newest_h_ff, newest_h_in, newest_v_ff, newest_v_in;

   logic [ieqc_pkg::IDX_W-1:0]  fill;
   logic                        empty;
   logic                        full;
   logic [ieqc_pkg::IDX_W-1:0]  newest_idx;
   logic                        mem_we;
   logic [ieqc_pkg::ADDR_W-1:0] mem_waddr;
   ieqc_pkg::entry_type         mem_wdata;
   logic                        mem_re;

   assign fill       = wr_ff - rd_ff;
   assign empty      = (fill == '0);
   assign full       = (fill == ieqc_pkg::IDX_W'(ieqc_pkg::QUEUE_DEPTH));
   assign newest_idx = wr_ff - ieqc_pkg::IDX_W'(1);

   assign status.op_recover = (op_ff == ieqc_pkg::OP_RECOVER);
   assign status.walk_last  = (walk_ff == ieqc_pkg::KEY_W'(ieqc_pkg::KEY_COUNT - 1));

   always_comb begin
      wr_in          = wr_ff;
      rd_in          = rd_ff;
      map_in         = map_ff;
      button_in      = button_ff;
      pos_h_in       = pos_h_ff;
      pos_v_in       = pos_v_ff;
      lost_in        = lost_ff;
      ev_valid_in    = ev_valid_ff;
      walk_in        = walk_ff;
      newest_kind_in = newest_kind_ff;
      newest_h_in    = newest_h_ff;
      newest_v_in    = newest_v_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_waddr      = wr_ff[ieqc_pkg::ADDR_W-1:0];
      mem_wdata      = '0;

      if (cmd.exec) begin
         ev_valid_in = 1'b0;
         case (op_ff)
            ieqc_pkg::OP_KEY: begin
               if (map_ff[key_ff] != down_ff) begin
                  if (full) begin
                     lost_in = 1'b1;
                  end else begin
                     mem_we         = 1'b1;
                     mem_wdata.kind = ieqc_pkg::KIND_KEY;
                     mem_wdata.key  = key_ff;
                     mem_wdata.down = down_ff;
                     wr_in          = wr_ff + ieqc_pkg::IDX_W'(1);
                     map_in[key_ff] = down_ff;
                  end
               end
            end
            ieqc_pkg::OP_BUTTON: begin
               if (button_ff != down_ff) begin
                  if (full) begin
                     lost_in = 1'b1;
                  end else begin
                     mem_we         = 1'b1;
                     mem_wdata.kind = ieqc_pkg::KIND_BUTTON;
                     mem_wdata.down = down_ff;
                     wr_in          = wr_ff + ieqc_pkg::IDX_W'(1);
                     button_in      = down_ff;
                  end
               end
            end
            ieqc_pkg::OP_DELTA: begin
               if (h_ff != '0 || v_ff != '0) begin
                  if (!empty && newest_kind_ff == ieqc_pkg::KIND_DELTA) begin
                     // fold into the newest entry, 16-bit wrap
                     mem_we         = 1'b1;
                     mem_waddr      = newest_idx[ieqc_pkg::ADDR_W-1:0];
                     mem_wdata.kind = ieqc_pkg::KIND_DELTA;
                     mem_wdata.h    = newest_h_ff + h_ff;
                     mem_wdata.v    = newest_v_ff + v_ff;
                  end else if (full) begin
                     lost_in = 1'b1;
                  end else begin
                     mem_we         = 1'b1;
                     mem_wdata.kind = ieqc_pkg::KIND_DELTA;
                     mem_wdata.h    = h_ff;
                     mem_wdata.v    = v_ff;
                     wr_in          = wr_ff + ieqc_pkg::IDX_W'(1);
                  end
               end
            end
            ieqc_pkg::OP_POS: begin
               if (h_ff != pos_h_ff || v_ff != pos_v_ff) begin
                  if (!empty && newest_kind_ff == ieqc_pkg::KIND_POS) begin
                     mem_we    = 1'b1;
                     mem_waddr = newest_idx[ieqc_pkg::ADDR_W-1:0];
                  end else if (full) begin
                     lost_in = 1'b1;
                  end else begin
                     mem_we = 1'b1;
                     wr_in  = wr_ff + ieqc_pkg::IDX_W'(1);
                  end
                  mem_wdata.kind = ieqc_pkg::KIND_POS;
                  mem_wdata.h    = h_ff;
                  mem_wdata.v    = v_ff;
                  if (mem_we) begin
                     pos_h_in = h_ff;
                     pos_v_in = v_ff;
                  end
               end
            end
            ieqc_pkg::OP_POP: begin
               if (!empty) begin
                  mem_re      = 1'b1;
                  ev_valid_in = 1'b1;
                  rd_in       = rd_ff + ieqc_pkg::IDX_W'(1);
               end
            end
            ieqc_pkg::OP_RECOVER: begin
               lost_in = 1'b0;
               walk_in = '0;
               if (button_ff) begin
                  if (full) begin
                     lost_in = 1'b1;
                  end else begin
                     mem_we         = 1'b1;
                     mem_wdata.kind = ieqc_pkg::KIND_BUTTON;
                     wr_in          = wr_ff + ieqc_pkg::IDX_W'(1);
                     button_in      = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.walk) begin
         walk_in = walk_ff + ieqc_pkg::KEY_W'(1);
         if (map_ff[walk_ff]) begin
            if (full) begin
               lost_in = 1'b1;
            end else begin
               mem_we          = 1'b1;
               mem_wdata.kind  = ieqc_pkg::KIND_KEY;
               mem_wdata.key   = walk_ff;
               wr_in           = wr_ff + ieqc_pkg::IDX_W'(1);
               map_in[walk_ff] = 1'b0;
            end
         end
      end

      if (mem_we) begin
         newest_kind_in = mem_wdata.kind;
         newest_h_in    = mem_wdata.h;
         newest_v_in    = mem_wdata.v;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[rd_ff[ieqc_pkg::ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= in_op;
         key_ff  <= in_key;
         down_ff <= in_pressed;
         h_ff    <= in_h;
         v_ff    <= in_v;
      end
      newest_kind_ff <= newest_kind_in;
      newest_h_ff    <= newest_h_in;
      newest_v_ff    <= newest_v_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff       <= '0;
         rd_ff       <= '0;
         map_ff      <= '0;
         button_ff   <= 1'b0;
         pos_h_ff    <= '0;
         pos_v_ff    <= '0;
         lost_ff     <= 1'b0;
         ev_valid_ff <= 1'b0;
         walk_ff     <= '0;
      end else begin
         wr_ff       <= wr_in;
         rd_ff       <= rd_in;
         map_ff      <= map_in;
         button_ff   <= button_in;
         pos_h_ff    <= pos_h_in;
         pos_v_ff    <= pos_v_in;
         lost_ff     <= lost_in;
         ev_valid_ff <= ev_valid_in;
         walk_ff     <= walk_in;
      end
   end

   // report zeros unless a pop returned an entry
   assign ev_valid   = ev_valid_ff;
   assign ev_kind    = ev_valid_ff ? rdata_ff.kind : 2'd0;
   assign ev_key     = ev_valid_ff ? rdata_ff.key : '0;
   assign ev_down    = ev_valid_ff ? rdata_ff.down : 1'b0;
   assign ev_h       = ev_valid_ff ? rdata_ff.h : 16'd0;
   assign ev_v       = ev_valid_ff ? rdata_ff.v : 16'd0;
   assign lost_flag  = lost_ff;
   assign fill_level = 6'(fill);

endmodule

// ===== rtl/input_event_queue_coalescing.sv =====
// Keyboard and mouse event queue with coalescing of repeated mouse motion.
// Request channel (req_): one transaction per command; req_tuser carries the
// opcode (key, button, delta, position, pop, recover), req_tdata the key
// number, the pressed flag and the horizontal and vertical values.
// Response channel (rsp_): exactly one transaction per request; rsp_tuser
// says whether a pop returned an entry and of which kind, rsp_tdata carries
// the entry fields, the sticky lost flag and the fill level after the command.
// A taken request is carried out in the controller's execute state before
// rsp_tvalid rises; recover also walks the pressed-key map, one key a cycle,
// and raises rsp_tvalid once the last key has been visited. Only one
// command is in flight at a time: req_tready stays low from the moment a
// request is taken until its response has been taken.
// Reset clears the queue, the key map, the button and position state and the
// lost flag; queue storage itself is not cleared.
// While the receiver stalls the response is held stable and req_tready stays
// low until the response is taken.
module input_event_queue_coalescing (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // op
   input  logic [39:0] req_tdata,   // key_code, pressed, h_value, v_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // ev_valid, ev_kind
   output logic [47:0] rsp_tdata    // ev_key, ev_down, ev_h, ev_v, lost_flag, fill_level, pad
);

   ieqc_pkg::cmd_type    cmd;
   ieqc_pkg::status_type status;

   logic                       ev_valid;
   logic [1:0]                 ev_kind;
   logic [ieqc_pkg::KEY_W-1:0] ev_key;
   logic                       ev_down;
   logic [15:0]                ev_h;
   logic [15:0]                ev_v;
   logic                       lost_flag;
   logic [5:0]                 fill_level;

   ieqc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ieqc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .in_op      (req_tuser),
      .in_key     (req_tdata[6:0]),
      .in_pressed (req_tdata[7]),
      .in_h       (req_tdata[23:8]),
      .in_v       (req_tdata[39:24]),
      .ev_valid   (ev_valid),
      .ev_kind    (ev_kind),
      .ev_key     (ev_key),
      .ev_down    (ev_down),
      .ev_h       (ev_h),
      .ev_v       (ev_v),
      .lost_flag  (lost_flag),
      .fill_level (fill_level)
   );

   assign rsp_tuser = {ev_kind, ev_valid};
   assign rsp_tdata = {1'b0, fill_level, lost_flag, ev_v, ev_h, ev_down, ev_key};

endmodule

// ===== sim/input_event_queue_coalescing_test.sv =====
`timescale 1ns / 100ps

module input_event_queue_coalescing_test;

   localparam int unsigned SPAN        = 2 * ieqc_pkg::QUEUE_DEPTH;
   localparam int          ITEM_TARGET = 1450;
   localparam int          PLAN_ROWS   = 23;

   // op codes the block has no use for
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   typedef enum {MIXED_TRAFFIC, MOUSE_MOTION, KEY_FLOOD, QUEUE_DRAIN, RAW_NOISE} episode_type;

   typedef struct packed {
      logic                       valid;
      logic [1:0]                 kind;
      logic [ieqc_pkg::KEY_W-1:0] key;
      logic                       down;
      logic [15:0]                h;
      logic [15:0]                v;
      logic                       lost;
      logic [5:0]                 fill;
   } event_reply_type;

   // typed rows give the reply in full; event h and v are zero there
   typedef struct packed {
      logic [2:0]                 op;
      logic [ieqc_pkg::KEY_W-1:0] key;
      logic                       down;
      logic [15:0]                h;
      logic [15:0]                v;
      logic                       typed;
      logic                       r_valid;
      logic [1:0]                 r_kind;
      logic [ieqc_pkg::KEY_W-1:0] r_key;
      logic                       r_down;
      logic                       r_lost;
      logic [5:0]                 r_fill;
   } plan_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser  = '0;
   logic [39:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [2:0]  rsp_tuser;
   logic [47:0] rsp_tdata;

   // mirror of the queue and the coalescing state
   ieqc_pkg::entry_type            queue_mem [ieqc_pkg::QUEUE_DEPTH];
   int unsigned                    wr_count   = 0;
   int unsigned                    rd_count   = 0;
   logic [ieqc_pkg::KEY_COUNT-1:0] keys_held  = '0;
   logic                           mouse_held = 1'b0;
   logic [15:0]                    pos_h      = '0;
   logic [15:0]                    pos_v      = '0;
   logic                           overflowed = 1'b0;

   event_reply_type awaited_replies [$];
   int              mismatches    = 0;
   int              counted_items = 0;
   bit              calm          = 1'b0;

   plan_row_type plan [PLAN_ROWS] = '{
      '{ieqc_pkg::OP_POP,     7'd0,   1'b0, 16'h0000, 16'h0000,
        1'b1, 1'b0, ieqc_pkg::KIND_KEY, 7'd0, 1'b0, 1'b0, 6'd0},
      '{OP_SPARE_A,           7'd127, 1'b1, 16'hffff, 16'hffff,
        1'b1, 1'b0, ieqc_pkg::KIND_KEY, 7'd0, 1'b0, 1'b0, 6'd0},
      '{OP_SPARE_B,           7'd85,  1'b1, 16'ha5a5, 16'h5a5a,
        1'b1, 1'b0, ieqc_pkg::KIND_KEY, 7'd0, 1'b0, 1'b0, 6'd0},
      '{ieqc_pkg::OP_KEY,     7'd0,   1'b1, 16'h0000, 16'h0000,
        1'b1, 1'b0, ieqc_pkg::KIND_KEY, 7'd0, 1'b0, 1'b0, 6'd1},
      '{ieqc_pkg::OP_KEY,     7'd127, 1'b1, 16'hffff, 16'hffff,
        1'b1, 1'b0, ieqc_pkg::KIND_KEY, 7'd0, 1'b0, 1'b0, 6'd2},
      '{ieqc_pkg::OP_KEY,     7'd127, 1'b1, 16'h0000, 16'h0000,
        1'b1, 1'b0, ieqc_pkg::KIND_KEY, 7'd0, 1'b0, 1'b0, 6'd2},
      '{ieqc_pkg::OP_BUTTON,  7'd0,   1'b1, 16'h0000, 16'h0000,
        1'b1, 1'b0, ieqc_pkg::KIND_KEY, 7'd0, 1'b0, 1'b0, 6'd3},
      '{ieqc_pkg::OP_BUTTON,  7'd0,   1'b1, 16'h0000, 16'h0000,
        1'b1, 1'b0, ieqc_pkg::KIND_KEY, 7'd0, 1'b0, 1'b0, 6'd3},
      '{ieqc_pkg::OP_DELTA,   7'd0,   1'b0, 16'h0000, 16'h0000,
        1'b1, 1'b0, ieqc_pkg::KIND_KEY, 7'd0, 1'b0, 1'b0, 6'd3},
      '{ieqc_pkg::OP_DELTA,   7'd0,   1'b0, 16'hffff, 16'h0001,
        1'b1, 1'b0, ieqc_pkg::KIND_KEY, 7'd0, 1'b0, 1'b0, 6'd4},
      '{ieqc_pkg::OP_DELTA,   7'd0,   1'b0, 16'h0001, 16'hffff,
        1'b1, 1'b0, ieqc_pkg::KIND_KEY, 7'd0, 1'b0, 1'b0, 6'd4},
      '{ieqc_pkg::OP_POS,     7'd0,   1'b0, 16'h0000, 16'h0000,
        1'b1, 1'b0, ieqc_pkg::KIND_KEY, 7'd0, 1'b0, 1'b0, 6'd4},
      '{ieqc_pkg::OP_POS,     7'd0,   1'b0, 16'hffff, 16'hffff,
        1'b1, 1'b0, ieqc_pkg::KIND_KEY, 7'd0, 1'b0, 1'b0, 6'd5},
      '{ieqc_pkg::OP_POS,     7'd0,   1'b0, 16'h1234, 16'h8000,
        1'b1, 1'b0, ieqc_pkg::KIND_KEY, 7'd0, 1'b0, 1'b0, 6'd5},
      '{ieqc_pkg::OP_KEY,     7'd5,   1'b0, 16'h0000, 16'h0000,
        1'b1, 1'b0, ieqc_pkg::KIND_KEY, 7'd0, 1'b0, 1'b0, 6'd5},
      '{ieqc_pkg::OP_POP,     7'd0,   1'b0, 16'h0000, 16'h0000,
        1'b1, 1'b1, ieqc_pkg::KIND_KEY, 7'd0, 1'b1, 1'b0, 6'd4},
      '{ieqc_pkg::OP_POP,     7'd0,   1'b0, 16'h0000, 16'h0000,
        1'b1, 1'b1, ieqc_pkg::KIND_KEY, 7'd127, 1'b1, 1'b0, 6'd3},
      '{ieqc_pkg::OP_POP,     7'd0,   1'b0, 16'h0000, 16'h0000,
        1'b1, 1'b1, ieqc_pkg::KIND_BUTTON, 7'd0, 1'b1, 1'b0, 6'd2},
      '{ieqc_pkg::OP_POP,     7'd0,   1'b0, 16'h0000, 16'h0000,
        1'b0, 1'b0, ieqc_pkg::KIND_KEY, 7'd0, 1'b0, 1'b0, 6'd0},
      '{ieqc_pkg::OP_POP,     7'd0,   1'b0, 16'h0000, 16'h0000,
        1'b0, 1'b0, ieqc_pkg::KIND_KEY, 7'd0, 1'b0, 1'b0, 6'd0},
      '{ieqc_pkg::OP_KEY,     7'd127, 1'b0, 16'h0000, 16'h0000,
        1'b0, 1'b0, ieqc_pkg::KIND_KEY, 7'd0, 1'b0, 1'b0, 6'd0},
      '{ieqc_pkg::OP_RECOVER, 7'd0,   1'b0, 16'h0000, 16'h0000,
        1'b0, 1'b0, ieqc_pkg::KIND_KEY, 7'd0, 1'b0, 1'b0, 6'd0},
      '{ieqc_pkg::OP_RECOVER, 7'd0,   1'b0, 16'h0000, 16'h0000,
        1'b0, 1'b0, ieqc_pkg::KIND_KEY, 7'd0, 1'b0, 1'b0, 6'd0}
   };

   input_event_queue_coalescing dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),   // op
      .req_tdata  (req_tdata),   // key_code, pressed, h_value, v_value
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),   // ev_valid, ev_kind
      .rsp_tdata  (rsp_tdata)    // ev_key, ev_down, ev_h, ev_v, lost_flag, fill_level, pad
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned held_count();
      return (wr_count + SPAN - rd_count) % SPAN;
   endfunction

   function automatic int newest_slot();
      return int'(((wr_count + SPAN - 1) % SPAN) % ieqc_pkg::QUEUE_DEPTH);
   endfunction

   // take a fresh entry, or mark the loss when the queue is full
   function automatic int claim_slot();
      int slot;
      if (held_count() >= ieqc_pkg::QUEUE_DEPTH) begin
         overflowed = 1'b1;
         return -1;
      end
      slot = int'(wr_count % ieqc_pkg::QUEUE_DEPTH);
      queue_mem[slot] = '0;
      wr_count = (wr_count + 1) % SPAN;
      return slot;
   endfunction

   function automatic void log_key(input logic [ieqc_pkg::KEY_W-1:0] key, input logic down);
      int slot;
      if (keys_held[key] == down)
         return;
      slot = claim_slot();
      if (slot < 0)
         return;
      queue_mem[slot].kind = ieqc_pkg::KIND_KEY;
      queue_mem[slot].key  = key;
      queue_mem[slot].down = down;
      keys_held[key] = down;
   endfunction

   function automatic void log_button(input logic down);
      int slot;
      if (mouse_held == down)
         return;
      slot = claim_slot();
      if (slot < 0)
         return;
      queue_mem[slot].kind = ieqc_pkg::KIND_BUTTON;
      queue_mem[slot].down = down;
      mouse_held = down;
   endfunction

   function automatic event_reply_type coalesce_command(input logic [2:0] op,
         input logic [ieqc_pkg::KEY_W-1:0] key, input logic down, input logic [15:0] h,
         input logic [15:0] v);
      event_reply_type     reply;
      ieqc_pkg::entry_type oldest;
      int                  slot;
      reply = '0;
      case (op)
         ieqc_pkg::OP_KEY:    log_key(key, down);
         ieqc_pkg::OP_BUTTON: log_button(down);
         ieqc_pkg::OP_DELTA: begin
            if (h != '0 || v != '0) begin
               // fold into the newest entry while it is still a delta
               if (held_count() != 0 &&
                     queue_mem[newest_slot()].kind == ieqc_pkg::KIND_DELTA) begin
                  slot = newest_slot();
                  queue_mem[slot].h = queue_mem[slot].h + h;
                  queue_mem[slot].v = queue_mem[slot].v + v;
               end else begin
                  slot = claim_slot();
                  if (slot >= 0) begin
                     queue_mem[slot].kind = ieqc_pkg::KIND_DELTA;
                     queue_mem[slot].h    = h;
                     queue_mem[slot].v    = v;
                  end
               end
            end
         end
         ieqc_pkg::OP_POS: begin
            if (h != pos_h || v != pos_v) begin
               if (held_count() != 0 &&
                     queue_mem[newest_slot()].kind == ieqc_pkg::KIND_POS)
                  slot = newest_slot();
               else
                  slot = claim_slot();
               if (slot >= 0) begin
                  queue_mem[slot] = '0;
                  queue_mem[slot].kind = ieqc_pkg::KIND_POS;
                  queue_mem[slot].h    = h;
                  queue_mem[slot].v    = v;
                  pos_h = h;
                  pos_v = v;
               end
            end
         end
         ieqc_pkg::OP_POP: begin
            if (held_count() != 0) begin
               oldest = queue_mem[rd_count % ieqc_pkg::QUEUE_DEPTH];
               reply.valid = 1'b1;
               reply.kind  = oldest.kind;
               reply.key   = oldest.key;
               reply.down  = oldest.down;
               reply.h     = oldest.h;
               reply.v     = oldest.v;
               rd_count = (rd_count + 1) % SPAN;
            end
         end
         ieqc_pkg::OP_RECOVER: begin
            overflowed = 1'b0;
            log_button(1'b0);
            for (int k = 0; k < ieqc_pkg::KEY_COUNT; k++)
               if (keys_held[k])
                  log_key(ieqc_pkg::KEY_W'(k), 1'b0);
         end
         default: ;
      endcase
      reply.lost = overflowed;
      reply.fill = 6'(held_count());
      return reply;
   endfunction

   function automatic bit take_break();
      return !calm && ($urandom_range(99) < 38);
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("ERROR at %0t ns: %s", $time, msg);
   endtask

   task automatic check_field(input string label, input logic [15:0] got,
         input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s: got %0h, expected %0h", label, got, want));
   endtask

   task automatic issue(input logic [2:0] op, input logic [ieqc_pkg::KEY_W-1:0] key,
         input logic down, input logic [15:0] h, input logic [15:0] v,
         input logic typed, input event_reply_type typed_reply);
      event_reply_type predicted;
      while (take_break()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {v, h, down, key};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predicted = coalesce_command(op, key, down, h, v);
      awaited_replies.push_back(typed ? typed_reply : predicted);
      if (op <= ieqc_pkg::OP_RECOVER)
         counted_items++;
   endtask

   task automatic random_item(input episode_type style);
      logic [2:0]                 op;
      logic [ieqc_pkg::KEY_W-1:0] key;
      logic                       down;
      logic [15:0]                h;
      logic [15:0]                v;
      int unsigned                roll;
      int unsigned                shape;
      key   = ieqc_pkg::KEY_W'($urandom_range(ieqc_pkg::KEY_COUNT - 1));
      down  = 1'($urandom_range(1));
      h     = 16'($urandom_range(65535));
      v     = 16'($urandom_range(65535));
      roll  = $urandom_range(99);
      shape = $urandom_range(7);
      case (style)
         MIXED_TRAFFIC: begin
            // a narrow key range so presses are often followed by releases
            if (shape[0])
               key[ieqc_pkg::KEY_W-1:4] = '0;
            op = roll < 25 ? ieqc_pkg::OP_KEY : roll < 35 ? ieqc_pkg::OP_BUTTON :
                 roll < 50 ? ieqc_pkg::OP_DELTA : roll < 65 ? ieqc_pkg::OP_POS :
                 roll < 97 ? ieqc_pkg::OP_POP : ieqc_pkg::OP_RECOVER;
         end
         MOUSE_MOTION: op = roll < 35 ? ieqc_pkg::OP_DELTA :
                            roll < 70 ? ieqc_pkg::OP_POS : ieqc_pkg::OP_POP;
         KEY_FLOOD: begin
            op   = roll < 92 ? ieqc_pkg::OP_KEY : ieqc_pkg::OP_BUTTON;
            down = 1'b1;
         end
         QUEUE_DRAIN: op = roll < 92 ? ieqc_pkg::OP_POP : ieqc_pkg::OP_RECOVER;
         default: op = 3'($urandom_range(7));
      endcase
      if (op == ieqc_pkg::OP_DELTA && shape == 0) begin
         h = '0;
         v = '0;
      end else if (op == ieqc_pkg::OP_DELTA && shape < 4) begin
         h = 16'(int'($urandom_range(16)) - 8);
         v = 16'(int'($urandom_range(16)) - 8);
      end
      // repeat the last position now and then so that it is dropped
      if (op == ieqc_pkg::OP_POS && shape < 2) begin
         h = pos_h;
         v = pos_v;
      end
      issue(op, key, down, h, v, 1'b0, '0);
   endtask

   always @(posedge clock) begin
      event_reply_type want;
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= calm || ($urandom_range(99) >= 38);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_replies.size() == 0) begin
            report_mismatch("response transaction with no request outstanding");
         end else begin
            want = awaited_replies.pop_front();
            check_field("ev_valid",   16'(rsp_tuser[0]),      16'(want.valid));
            check_field("ev_kind",    16'(rsp_tuser[2:1]),    16'(want.kind));
            check_field("ev_key",     16'(rsp_tdata[6:0]),    16'(want.key));
            check_field("ev_down",    16'(rsp_tdata[7]),      16'(want.down));
            check_field("ev_h",       rsp_tdata[23:8],        want.h);
            check_field("ev_v",       rsp_tdata[39:24],       want.v);
            check_field("lost_flag",  16'(rsp_tdata[40]),     16'(want.lost));
            check_field("fill_level", 16'(rsp_tdata[46:41]),  16'(want.fill));
         end
      end
   end

   initial begin
      #8_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      event_reply_type typed_reply;
      int unsigned     pick;
      int              waited;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         typed_reply       = '0;
         typed_reply.valid = plan[i].r_valid;
         typed_reply.kind  = plan[i].r_kind;
         typed_reply.key   = plan[i].r_key;
         typed_reply.down  = plan[i].r_down;
         typed_reply.lost  = plan[i].r_lost;
         typed_reply.fill  = plan[i].r_fill;
         issue(plan[i].op, plan[i].key, plan[i].down, plan[i].h, plan[i].v,
               plan[i].typed, typed_reply);
      end

      while (counted_items < ITEM_TARGET) begin
         calm = ($urandom_range(4) == 0);
         pick = $urandom_range(9);
         if (pick < 5) begin
            repeat ($urandom_range(60, 20)) random_item(MIXED_TRAFFIC);
         end else if (pick < 7) begin
            repeat ($urandom_range(50, 20)) random_item(MOUSE_MOTION);
         end else if (pick < 9) begin
            // overrun the queue, recover while it is still full, then drain
            repeat ($urandom_range(45, 30)) random_item(KEY_FLOOD);
            issue(ieqc_pkg::OP_RECOVER, '0, 1'b0, '0, '0, 1'b0, '0);
            repeat ($urandom_range(50, 20)) random_item(QUEUE_DRAIN);
         end else begin
            repeat ($urandom_range(20, 5)) random_item(RAW_NOISE);
         end
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      waited = 0;
      while (awaited_replies.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      if (awaited_replies.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", awaited_replies.size()));
      repeat (10) @(posedge clock);

      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
